// File: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Depends on nothing; used by every module of the block except tcw_ram.
package tcw_pkg;

   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = CHAR_W + ATTR_W;

   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_LINES   = 25;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'h0A;
   localparam logic              DEFAULT_ENABLE = 1'b1;
   localparam logic [ATTR_W-1:0] DEFAULT_ATTR   = 8'h07;

   // Register indexes of the config port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTR   = 1'b1;

   // Function codes of an input transaction
   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam int QUEUE_DEPTH = 2;

   // Command class decided by the front end
   typedef enum logic [2:0] {
      OP_CHAR,       // store character, advance cursor
      OP_NEWLINE,    // new line
      OP_NOP,        // put while disabled
      OP_READ,       // read one cell inside the grid
      OP_READ_OFF    // read outside the grid, answers zero
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [CHAR_W-1:0]  code;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
   } cmd_type;

   // Engine to front end handshake
   typedef struct packed {
      logic pop;      // engine takes the queue head this cycle
      logic ready;    // power-up clear finished
   } back_ctl_type;

endpackage

// File: rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 2000,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/tcw_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on tcw_pkg.
module tcw_front #(
   parameter int COLUMNS = tcw_pkg::SCREEN_COLUMNS,
   parameter int LINES   = tcw_pkg::SCREEN_LINES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_func,
   input  logic [tcw_pkg::CHAR_W-1:0] req_code,
   input  logic [tcw_pkg::ROW_W-1:0]  req_row,
   input  logic [tcw_pkg::COL_W-1:0]  req_col,
   input  logic                       console_enable,
   input  tcw_pkg::back_ctl_type      back_ctl,
   output logic                       cmd_valid,
   output tcw_pkg::cmd_type           cmd
);
   import tcw_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   cmd_type           new_cmd;
   logic              push;
   logic              off_grid;

   // Classify the incoming transaction
   always_comb begin
      off_grid = ((ROW_W + 1)'(req_row) >= (ROW_W + 1)'(LINES)) ||
                 ((COL_W + 1)'(req_col) >= (COL_W + 1)'(COLUMNS));
      new_cmd.code = req_code;
      new_cmd.row  = req_row;
      new_cmd.col  = req_col;
      if (req_func == FUNC_READ) begin
         new_cmd.op = off_grid ? OP_READ_OFF : OP_READ;
      end else if (!console_enable) begin
         new_cmd.op = OP_NOP;
      end else if (req_code == NEWLINE_CODE) begin
         new_cmd.op = OP_NEWLINE;
      end else begin
         new_cmd.op = OP_CHAR;
      end
   end

   assign req_tready = back_ctl.ready && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (back_ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !back_ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && back_ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// File: rtl/tcw_back.sv
// Back end: cursor, row-rotation scroll, cell RAM access and the result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_back #(
   parameter int COLUMNS = tcw_pkg::SCREEN_COLUMNS,
   parameter int LINES   = tcw_pkg::SCREEN_LINES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  tcw_pkg::cmd_type           cmd,
   output tcw_pkg::back_ctl_type      back_ctl,
   input  logic [tcw_pkg::ATTR_W-1:0] cell_attribute,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tcw_pkg::CHAR_W-1:0] rsp_char,
   output logic [tcw_pkg::ATTR_W-1:0] rsp_attr,
   output logic [tcw_pkg::COL_W-1:0]  rsp_column,
   output logic [tcw_pkg::ROW_W-1:0]  rsp_line
);
   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * LINES;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } state_type;

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [ROW_W-1:0]   top_ff, top_in;        // physical row shown as line 0
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [ROW_W-1:0]   scr_row_ff, scr_row_in;
   logic [COL_W-1:0]   scr_col_ff, scr_col_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]  rsp_attr_ff, rsp_attr_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;

   logic               take;
   logic               ram_we;
   logic [CELL_W-1:0]  ram_wdata;
   logic [CELL_W-1:0]  ram_rdata;
   logic [ADDR_W-1:0]  ram_addr;
   logic [ROW_W-1:0]   addr_line;     // logical line, rotated by top
   logic [ROW_W-1:0]   addr_prow;     // physical row
   logic [COL_W-1:0]   addr_col;
   logic               use_prow;
   logic [ROW_W:0]     rot_sum;

   // Map line/column to a RAM address through the row rotation
   always_comb begin
      rot_sum = (ROW_W + 1)'(addr_line) + (ROW_W + 1)'(top_ff);
      if (rot_sum >= (ROW_W + 1)'(LINES)) begin
         rot_sum = rot_sum - (ROW_W + 1)'(LINES);
      end
      if (state_ff == ST_CLEAR) begin
         ram_addr = sweep_ff;
      end else if (use_prow) begin
         ram_addr = ADDR_W'(addr_prow) * ADDR_W'(COLUMNS) + ADDR_W'(addr_col);
      end else begin
         ram_addr = ADDR_W'(rot_sum[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(addr_col);
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (ram_wdata),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   assign take = (state_ff == ST_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_tready);

   // Engine control
   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      top_in       = top_ff;
      sweep_in     = sweep_ff;
      scr_row_in   = scr_row_ff;
      scr_col_in   = scr_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      ram_we       = 1'b0;
      ram_wdata    = '0;
      addr_line    = cur_row_ff;
      addr_prow    = scr_row_ff;
      addr_col     = cur_col_ff;
      use_prow     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               if (cmd.op == OP_READ) begin
                  addr_line = cmd.row;
                  addr_col  = cmd.col;
                  state_in  = ST_READ;
               end else begin
                  // Put and off-grid reads answer right away
                  if (cmd.op == OP_CHAR) begin
                     ram_we     = 1'b1;
                     ram_wdata  = {cell_attribute, cmd.code};
                     cur_col_in = cur_col_ff + 1'b1;
                  end
                  if ((cmd.op == OP_NEWLINE) || ((cmd.op == OP_CHAR) &&
                      (cur_col_ff == COL_W'(COLUMNS - 1)))) begin
                     cur_col_in = '0;
                     if (cur_row_ff == ROW_W'(LINES - 1)) begin
                        // Scroll: rotate rows, blank the old top row
                        top_in     = (top_ff == ROW_W'(LINES - 1)) ? '0 : top_ff + 1'b1;
                        scr_row_in = top_ff;
                        scr_col_in = '0;
                        state_in   = ST_SCROLL;
                     end else begin
                        cur_row_in = cur_row_ff + 1'b1;
                     end
                  end
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = '0;
                  rsp_attr_in  = '0;
                  rsp_col_in   = cur_col_in;
                  rsp_row_in   = cur_row_in;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = ram_rdata[CHAR_W-1:0];
            rsp_attr_in  = ram_rdata[CELL_W-1:CHAR_W];
            rsp_col_in   = cur_col_ff;
            rsp_row_in   = cur_row_ff;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            use_prow   = 1'b1;
            addr_col   = scr_col_ff;
            ram_we     = 1'b1;
            scr_col_in = scr_col_ff + 1'b1;
            if (scr_col_ff == COL_W'(COLUMNS - 1)) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         top_ff       <= '0;
         sweep_ff     <= '0;
         scr_row_ff   <= '0;
         scr_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         scr_row_ff   <= scr_row_in;
         scr_col_ff   <= scr_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign back_ctl.pop   = take;
   assign back_ctl.ready = (state_ff != ST_CLEAR);
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_char       = rsp_char_ff;
   assign rsp_attr       = rsp_attr_ff;
   assign rsp_column     = rsp_col_ff;
   assign rsp_line       = rsp_row_ff;

endmodule

// File: rtl/text_console_writer_top.sv
// Text console writer top level: config registers, front end queue and engine.
// Depends on tcw_pkg, tcw_front, tcw_back (and tcw_ram below it).
//
//  Channel  | Ports              | Payload
//  ---------+--------------------+-------------------------------------------
//  request  | req_t*             | tuser: func; tdata: char_code, row, col
//  response | rsp_t*             | tdata: cell_char, cell_attr, column, line
//  config   | csr_we/index/wdata | 0: console_enable, 1: cell_attribute
//
// The engine takes a queued transaction once it is idle and the response register
// is free; the response of a put or an off-grid read is registered from that take,
// that of an in-grid read passes the registered RAM read and the READ state first.
// A new line or a wrap on the last line keeps the engine busy in the scroll state
// while it blanks the recycled row; scrolling itself is a row-pointer rotation.
// After reset the engine zeroes all COLUMNS*LINES cells, with req_tready low; config
// writes are taken meanwhile. The two-entry queue and the response register let
// either side stall alone.
module text_console_writer_top #(
   parameter int COLUMNS = tcw_pkg::SCREEN_COLUMNS,
   parameter int LINES   = tcw_pkg::SCREEN_LINES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // char_code, read_row, read_col, pad
   input  logic                          req_tuser,   // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // cell_char, cell_attr, column, line, pad
   input  logic                          csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_wdata
);
   import tcw_pkg::*;

   logic               enable_ff;
   logic [ATTR_W-1:0]  attr_ff;
   logic               cmd_valid;
   cmd_type            cmd;
   back_ctl_type       back_ctl;
   logic [CHAR_W-1:0]  rsp_char;
   logic [ATTR_W-1:0]  rsp_attr;
   logic [COL_W-1:0]   rsp_column;
   logic [ROW_W-1:0]   rsp_line;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= DEFAULT_ENABLE;
         attr_ff   <= DEFAULT_ATTR;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_ATTR:   attr_ff   <= csr_wdata;
         endcase
      end
   end

   tcw_front #(
      .COLUMNS (COLUMNS),
      .LINES   (LINES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_func       (req_tuser),
      .req_code       (req_tdata[7:0]),
      .req_row        (req_tdata[12:8]),
      .req_col        (req_tdata[19:13]),
      .console_enable (enable_ff),
      .back_ctl       (back_ctl),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .LINES   (LINES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .back_ctl       (back_ctl),
      .cell_attribute (attr_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_char       (rsp_char),
      .rsp_attr       (rsp_attr),
      .rsp_column     (rsp_column),
      .rsp_line       (rsp_line)
   );

   assign rsp_tdata = {4'b0000, rsp_line, rsp_column, rsp_attr, rsp_char};

endmodule

// File: rtl/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_top.
module tcw_checker #(
   parameter int COLUMNS = tcw_pkg::SCREEN_COLUMNS,
   parameter int LINES   = tcw_pkg::SCREEN_LINES
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Clearing pass blocks input right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input accepted during power-up clear");

   // No response survives reset
   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Reported cursor stays on the grid
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[22:16]} < 8'(COLUMNS)) &&
                     ({1'b0, rsp_tdata[27:23]} < 6'(LINES)))
      else $error("cursor off the grid");

endmodule

bind text_console_writer_top tcw_checker #(
   .COLUMNS (COLUMNS),
   .LINES   (LINES)
) u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/testbench.sv
// Self-checking testbench for the text console writer: streams put and read
// transactions, predicts every response from its own screen model and compares.
// Depends on tcw_pkg and text_console_writer_top (rtl folder).
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   typedef struct packed {
      logic              func;
      logic [CHAR_W-1:0] code;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } console_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic [ATTR_W-1:0] at;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  line;
   } cell_report_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;   // char_code, read_row, read_col, pad
   logic                 req_tuser;   // func
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;   // cell_char, cell_attr, column, line, pad
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ATTR_W-1:0]    csr_wdata;

   // Screen model and cursor as the block should hold them
   logic [CELL_W-1:0] screen_model [0:SCREEN_LINES-1][0:SCREEN_COLUMNS-1];
   int                cursor_x;
   int                cursor_y;
   logic              model_enable;
   logic [ATTR_W-1:0] model_attr;

   console_item_type pending_requests[$];
   cell_report_type  expected_reports[$];
   console_item_type item_on_bus;
   int               mismatch_count;
   int               send_idle_pct;
   int               recv_idle_pct;

   text_console_writer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // New line: below the last row the grid scrolls up and the bottom row blanks
   function automatic void take_line_feed();
      cursor_x = 0;
      cursor_y++;
      if (cursor_y >= SCREEN_LINES) begin
         cursor_y = SCREEN_LINES - 1;
         for (int r = 0; r < SCREEN_LINES - 1; r++)
            for (int c = 0; c < SCREEN_COLUMNS; c++)
               screen_model[r][c] = screen_model[r+1][c];
         for (int c = 0; c < SCREEN_COLUMNS; c++)
            screen_model[SCREEN_LINES-1][c] = '0;
      end
   endfunction

   // Apply one transaction to the screen model and return the response it owes
   function automatic cell_report_type predict_cell_report(console_item_type it);
      cell_report_type rep;
      rep = '0;
      if (it.func == FUNC_PUT) begin
         if (model_enable) begin
            if (it.code == NEWLINE_CODE) begin
               take_line_feed();
            end else begin
               screen_model[cursor_y][cursor_x] = {model_attr, it.code};
               cursor_x++;
               if (cursor_x >= SCREEN_COLUMNS)
                  take_line_feed();
            end
         end
      end else if (it.row < SCREEN_LINES && it.col < SCREEN_COLUMNS) begin
         rep.ch = screen_model[it.row][it.col][CHAR_W-1:0];
         rep.at = screen_model[it.row][it.col][CELL_W-1:CHAR_W];
      end
      rep.col  = cursor_x[COL_W-1:0];
      rep.line = cursor_y[ROW_W-1:0];
      return rep;
   endfunction

   function automatic void report_mismatch(string what, cell_report_type want,
                                           cell_report_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t %s: expected char %02h attr %02h col %0d line %0d,",
                   " got char %02h attr %02h col %0d line %0d"},
                  $realtime, what, want.ch, want.at, want.col, want.line,
                  got.ch, got.at, got.col, got.line);
   endfunction

   function automatic console_item_type put_item(logic [CHAR_W-1:0] code);
      console_item_type it;
      it = '0;
      it.func = FUNC_PUT;
      it.code = code;
      return it;
   endfunction

   function automatic console_item_type read_item(int row, int col);
      console_item_type it;
      it = '0;
      it.func = FUNC_READ;
      it.row  = row[ROW_W-1:0];
      it.col  = col[COL_W-1:0];
      return it;
   endfunction

   // Driver: hold the transaction until taken, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_reports.push_back(predict_cell_report(item_on_bus));
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               item_on_bus = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, item_on_bus.col, item_on_bus.row, item_on_bus.code};
               req_tuser  <= item_on_bus.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response with the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      cell_report_type got;
      cell_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[22:16], rsp_tdata[27:23]};
            if (expected_reports.size() == 0) begin
               report_mismatch("unexpected response", '0, got);
            end else begin
               want = expected_reports.pop_front();
               if (got !== want)
                  report_mismatch("response mismatch", want, got);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Block is idle once everything sent has been answered
   task automatic wait_console_idle();
      do @(negedge clock);
      while (!(pending_requests.size() == 0 && !req_tvalid && expected_reports.size() == 0));
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [ATTR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_ENABLE)
         model_enable = value[0];
      else
         model_attr = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly runs of printable text ending in new lines, with reads mixed in;
   // long runs force wrapping, the rest is noise over every field value
   task automatic queue_random_text(int count);
      int               added;
      int               run_len;
      console_item_type it;
      added = 0;
      while (added < count) begin
         if ($urandom_range(99) < 15) begin
            it.func = 1'($urandom_range(1));
            it.code = CHAR_W'($urandom_range(255));
            it.row  = ROW_W'($urandom_range(31));
            it.col  = COL_W'($urandom_range(127));
            pending_requests.push_back(it);
            added++;
         end else begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(80, 170) : $urandom_range(0, 40);
            for (int k = 0; k < run_len && added < count; k++) begin
               if ($urandom_range(9) == 0)
                  pending_requests.push_back(read_item(
                     $urandom_range(1) ? $urandom_range(20, 24) : $urandom_range(24),
                     $urandom_range(SCREEN_COLUMNS - 1)));
               else
                  pending_requests.push_back(put_item(CHAR_W'($urandom_range(8'h20, 8'h7E))));
               added++;
            end
            if (added < count && $urandom_range(4) != 0) begin
               pending_requests.push_back(put_item(NEWLINE_CODE));
               added++;
            end
         end
      end
   endtask

   // Overall time limit
   initial begin
      #10ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      mismatch_count = 0;
      cursor_x = 0;
      cursor_y = 0;
      model_enable = DEFAULT_ENABLE;
      model_attr   = DEFAULT_ATTR;
      for (int r = 0; r < SCREEN_LINES; r++)
         for (int c = 0; c < SCREEN_COLUMNS; c++)
            screen_model[r][c] = '0;
      send_idle_pct = 22;
      recv_idle_pct = 78;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: extreme codes, reads of fresh and blank cells
      pending_requests.push_back(put_item(8'h41));
      pending_requests.push_back(put_item(8'h00));
      pending_requests.push_back(put_item(8'hFF));
      pending_requests.push_back(read_item(0, 0));
      pending_requests.push_back(read_item(0, 1));
      pending_requests.push_back(read_item(0, 2));
      pending_requests.push_back(read_item(0, 3));
      wait_console_idle();

      // Full attribute, new line, corner cell and reads off the grid
      write_csr(CSR_ATTR, 8'hFF);
      pending_requests.push_back(put_item(NEWLINE_CODE));
      pending_requests.push_back(put_item(8'h80));
      pending_requests.push_back(read_item(1, 0));
      pending_requests.push_back(read_item(SCREEN_LINES - 1, SCREEN_COLUMNS - 1));
      pending_requests.push_back(read_item(SCREEN_LINES, 0));
      pending_requests.push_back(read_item(0, SCREEN_COLUMNS));
      pending_requests.push_back(read_item(31, 127));
      wait_console_idle();

      // Disabled: puts change nothing, reads still work
      write_csr(CSR_ENABLE, 8'h00);
      write_csr(CSR_ATTR, 8'h00);
      pending_requests.push_back(put_item(8'h42));
      pending_requests.push_back(put_item(NEWLINE_CODE));
      pending_requests.push_back(read_item(1, 0));
      pending_requests.push_back(read_item(0, 0));
      pending_requests.push_back(read_item(31, 127));
      wait_console_idle();

      // Random traffic under several settings
      write_csr(CSR_ENABLE, 8'h01);
      queue_random_text(500);
      wait_console_idle();

      send_idle_pct = 78;
      recv_idle_pct = 22;
      write_csr(CSR_ATTR, ATTR_W'($urandom_range(1, 254)));
      queue_random_text(400);
      wait_console_idle();

      write_csr(CSR_ENABLE, 8'h00);
      write_csr(CSR_ATTR, 8'h5A);
      queue_random_text(100);
      wait_console_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_ENABLE, 8'h01);
      write_csr(CSR_ATTR, 8'hFF);
      queue_random_text(500);
      wait_console_idle();

      // Let a trailing scroll finish and catch any stray response
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
